// ===== hw/rtl/mmr_pkg.sv =====
// ----------------------------------------------------------------------------
// mmr_pkg: shared types and constants for the min-max rescaler
// Item modes, configuration register indexes, sequencer states and fixed
// field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmr_pkg;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int CHAN_W     = 3;
    localparam int SAMPLE_W   = 24;
    localparam int TARGET_W   = 25;
    localparam int CFG_ADDR_W = 2;

    // channels at or above this index are never selected
    localparam int MAX_CHANNELS = 8;

    // 16-bit PCM output limits
    localparam int PCM16_MAX = 32767;

    // register reset values
    localparam logic signed [TARGET_W-1:0] TARGET_MIN_RST = -25'sd8388608;
    localparam logic signed [TARGET_W-1:0] TARGET_MAX_RST = 25'sd8388607;

    typedef enum logic [MODE_W-1:0] {
        MODE_MEASURE = 2'd0,
        MODE_RESCALE = 2'd1,
        MODE_CLEAR   = 2'd2
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SAMPLE_FORMAT    = 2'd0,
        CFG_TARGET_MIN       = 2'd1,
        CFG_TARGET_MAX       = 2'd2,
        CFG_SELECTED_CHANNEL = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_FMT,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/mmr_serial_mul.sv =====
// ----------------------------------------------------------------------------
// mmr_serial_mul: bit-serial unsigned multiplier
// Shift-and-add over the multiplier bits, one bit per cycle. The product
// shifts right through one register while the partial sum enters at the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmr_serial_mul #(
    parameter int AW = 24,
    parameter int BW = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic              done,
    output logic [AW+BW-1:0]  product
);

    localparam int CW = $clog2(BW + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [AW-1:0]    mcand_reg, mcand_next;
    logic [AW+BW-1:0] prod_reg, prod_next;
    logic [AW:0]      sum;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    // one multiplier bit per step, lsb first
    always_comb begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        sum = {1'b0, prod_reg[AW+BW-1:BW]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        if (start) begin
            mcand_next = a;
            prod_next  = {{AW{1'b0}}, b};
            cnt_next   = CW'(BW);
        end else if (cnt_reg != '0) begin
            prod_next = {sum, prod_reg[BW-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ===== hw/rtl/mmr_serial_div.sv =====
// ----------------------------------------------------------------------------
// mmr_serial_div: bit-serial restoring divider
// One quotient bit per cycle, msb first. Numerator bits shift out of the
// quotient register into the remainder; quotient bits shift in behind them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmr_serial_div #(
    parameter int NW = 49,
    parameter int DW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // trial subtract; remainder stays below the divisor
    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        shifted   = {rem_reg, quo_reg[NW-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        ge        = ~diff[DW+1];
        if (start) begin
            den_next = den;
            rem_next = '0;
            quo_next = num;
            cnt_next = CW'(NW);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[NW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/min_max_rescale.sv =====
// ----------------------------------------------------------------------------
// min_max_rescale: min-max rescaler for one channel of a PCM stream
// A selected rescale item is accepted in ST_IDLE and passes through ST_MUL
//   (serial multiply), ST_DIV (serial divide), ST_ADD and ST_FMT to ST_OUT;
//   passthrough items go straight to ST_OUT and range-error items through
//   ST_FMT. ST_OUT waits while the output holds an untaken result, and the
//   next item can be taken in the same cycle that the result appears. Measure
//   and clear items are handled in ST_IDLE alone. Synchronous active-low reset
//   clears the tracker, the registers to their defaults and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_rescale #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
    input  logic [4:0]  s_axis_tuser,   // [1:0] mode, [4:2] channel

    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] sample_out
    output logic [1:0]  m_axis_tuser,   // [0] saturated, [1] range_error

    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [24:0] cfg_wr_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int SHIFT = SAMPLE_BITS - 16;
    localparam int TW    = mmr_pkg::TARGET_W;
    localparam int PW    = SB + TW;          // product magnitude width
    localparam int VW    = PW + 2;           // signed result before format

    localparam logic signed [SB-1:0] TRK_MAX = SB'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [SB-1:0] TRK_MIN = ~TRK_MAX;
    localparam logic signed [VW-1:0] FS_HI   = VW'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [VW-1:0] FS_LO   = ~FS_HI;
    localparam logic signed [VW-1:0] P16_HI  = VW'(mmr_pkg::PCM16_MAX);
    localparam logic signed [VW-1:0] P16_LO  = ~P16_HI;
    localparam logic signed [VW-1:0] BIAS    = VW'(2 ** SHIFT - 1);

    // state
    mmr_pkg::state_t          state_reg, state_next;
    logic signed [SB-1:0]     running_min_reg, running_min_next;
    logic signed [SB-1:0]     running_max_reg, running_max_next;
    logic                     any_measured_reg, any_measured_next;
    logic                     sample_format_reg, sample_format_next;
    logic signed [TW-1:0]     target_min_reg, target_min_next;
    logic signed [TW-1:0]     target_max_reg, target_max_next;
    logic [2:0]               sel_ch_reg, sel_ch_next;
    logic                     m_valid_reg, m_valid_next;

    // payload
    logic                     neg_reg, neg_next;
    logic signed [VW-1:0]     v_reg, v_next;
    logic [23:0]              pend_sample_reg, pend_sample_next;
    logic                     pend_sat_reg, pend_sat_next;
    logic                     pend_rerr_reg, pend_rerr_next;
    logic [23:0]              m_data_reg, m_data_next;
    logic                     m_sat_reg, m_sat_next;
    logic                     m_rerr_reg, m_rerr_next;

    // input decode
    mmr_pkg::mode_t           in_mode;
    logic [2:0]               in_chan;
    logic                     in_sel;
    logic signed [SB-1:0]     u16;
    logic signed [SB-1:0]     in_units;
    logic                     range_bad;
    logic signed [SB:0]       diff_a;
    logic signed [TW:0]       diff_b;
    logic [SB-1:0]            mag_a;
    logic [TW-1:0]            mag_b;
    logic [SB-1:0]            den;

    // serial units
    logic                     mul_start, mul_done;
    logic [PW-1:0]            product;
    logic                     div_start, div_done;
    logic [PW-1:0]            quotient;

    // add and format
    logic signed [VW-1:0]     q_x, tmin_x;
    logic signed [VW-1:0]     v_biased, v_scaled, v_sat;
    logic                     v_clip;

    assign in_mode = mmr_pkg::mode_t'(s_axis_tuser[1:0]);
    assign in_chan = s_axis_tuser[4:2];
    assign in_sel  = (in_chan == sel_ch_reg)
                   && ({29'd0, in_chan} < 32'(mmr_pkg::MAX_CHANNELS));

    // sample to tracker units
    always_comb begin
        u16 = SB'($signed(s_axis_tdata[15:0]));
        u16 = u16 <<< SHIFT;
        in_units = sample_format_reg ? $signed(s_axis_tdata[SB-1:0]) : u16;
    end

    assign range_bad = !any_measured_reg || (running_max_reg <= running_min_reg);

    // operands in sign-magnitude form for the serial units
    assign diff_a = {in_units[SB-1], in_units} - {running_min_reg[SB-1], running_min_reg};
    assign diff_b = {target_max_reg[TW-1], target_max_reg}
                  - {target_min_reg[TW-1], target_min_reg};
    assign mag_a  = diff_a[SB] ? SB'(-diff_a) : diff_a[SB-1:0];
    assign mag_b  = diff_b[TW] ? TW'(-diff_b) : diff_b[TW-1:0];
    assign den    = SB'(running_max_reg - running_min_reg);

    mmr_serial_mul #(
        .AW (SB),
        .BW (TW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mag_a),
        .b       (mag_b),
        .done    (mul_done),
        .product (product)
    );

    mmr_serial_div #(
        .NW (PW),
        .DW (SB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (product),
        .den      (den),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_x    = {2'b00, quotient};
    assign tmin_x = VW'(target_min_reg);

    // output format: in 16-bit mode truncate toward zero to 16 bits, then clip; in 24-bit mode clip to full scale
    always_comb begin
        v_biased = v_reg + (v_reg[VW-1] ? BIAS : '0);
        v_scaled = v_biased >>> SHIFT;
        v_sat    = v_reg;
        v_clip   = 1'b0;
        if (!sample_format_reg) begin
            v_sat = v_scaled;
            if (v_scaled > P16_HI) begin
                v_sat  = P16_HI;
                v_clip = 1'b1;
            end else if (v_scaled < P16_LO) begin
                v_sat  = P16_LO;
                v_clip = 1'b1;
            end
        end else begin
            if (v_reg > FS_HI) begin
                v_sat  = FS_HI;
                v_clip = 1'b1;
            end else if (v_reg < FS_LO) begin
                v_sat  = FS_LO;
                v_clip = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= mmr_pkg::ST_IDLE;
            running_min_reg   <= TRK_MAX;
            running_max_reg   <= TRK_MIN;
            any_measured_reg  <= 1'b0;
            sample_format_reg <= 1'b0;
            target_min_reg    <= mmr_pkg::TARGET_MIN_RST;
            target_max_reg    <= mmr_pkg::TARGET_MAX_RST;
            sel_ch_reg        <= 3'd0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            running_min_reg   <= running_min_next;
            running_max_reg   <= running_max_next;
            any_measured_reg  <= any_measured_next;
            sample_format_reg <= sample_format_next;
            target_min_reg    <= target_min_next;
            target_max_reg    <= target_max_next;
            sel_ch_reg        <= sel_ch_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        neg_reg         <= neg_next;
        v_reg           <= v_next;
        pend_sample_reg <= pend_sample_next;
        pend_sat_reg    <= pend_sat_next;
        pend_rerr_reg   <= pend_rerr_next;
        m_data_reg      <= m_data_next;
        m_sat_reg       <= m_sat_next;
        m_rerr_reg      <= m_rerr_next;
    end

    // sequencer, tracker and configuration
    always_comb begin
        state_next         = state_reg;
        running_min_next   = running_min_reg;
        running_max_next   = running_max_reg;
        any_measured_next  = any_measured_reg;
        sample_format_next = sample_format_reg;
        target_min_next    = target_min_reg;
        target_max_next    = target_max_reg;
        sel_ch_next        = sel_ch_reg;
        m_valid_next       = m_valid_reg;
        neg_next           = neg_reg;
        v_next             = v_reg;
        pend_sample_next   = pend_sample_reg;
        pend_sat_next      = pend_sat_reg;
        pend_rerr_next     = pend_rerr_reg;
        m_data_next        = m_data_reg;
        m_sat_next         = m_sat_reg;
        m_rerr_next        = m_rerr_reg;
        mul_start          = 1'b0;
        div_start          = 1'b0;

        // result taken downstream
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mmr_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (in_mode)
                        mmr_pkg::MODE_MEASURE: begin
                            if (in_sel) begin
                                if (in_units < running_min_reg) begin
                                    running_min_next = in_units;
                                end
                                if (in_units > running_max_reg) begin
                                    running_max_next = in_units;
                                end
                                any_measured_next = 1'b1;
                            end
                        end
                        mmr_pkg::MODE_CLEAR: begin
                            running_min_next  = TRK_MAX;
                            running_max_next  = TRK_MIN;
                            any_measured_next = 1'b0;
                        end
                        mmr_pkg::MODE_RESCALE: begin
                            if (!in_sel) begin
                                pend_sample_next = s_axis_tdata;
                                pend_sat_next    = 1'b0;
                                pend_rerr_next   = 1'b0;
                                state_next       = mmr_pkg::ST_OUT;
                            end else if (range_bad) begin
                                v_next         = tmin_x;
                                pend_rerr_next = 1'b1;
                                state_next     = mmr_pkg::ST_FMT;
                            end else begin
                                neg_next       = diff_a[SB] ^ diff_b[TW];
                                pend_rerr_next = 1'b0;
                                mul_start      = 1'b1;
                                state_next     = mmr_pkg::ST_MUL;
                            end
                        end
                        default: ;  // unused mode: ignored
                    endcase
                end
            end
            mmr_pkg::ST_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = mmr_pkg::ST_DIV;
                end
            end
            mmr_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = mmr_pkg::ST_ADD;
                end
            end
            mmr_pkg::ST_ADD: begin
                v_next     = neg_reg ? (tmin_x - q_x) : (tmin_x + q_x);
                state_next = mmr_pkg::ST_FMT;
            end
            mmr_pkg::ST_FMT: begin
                pend_sample_next = v_sat[23:0];
                pend_sat_next    = v_clip;
                state_next       = mmr_pkg::ST_OUT;
            end
            mmr_pkg::ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next  = pend_sample_reg;
                    m_sat_next   = pend_sat_reg;
                    m_rerr_next  = pend_rerr_reg;
                    m_valid_next = 1'b1;
                    state_next   = mmr_pkg::ST_IDLE;
                end
            end
            default: state_next = mmr_pkg::ST_IDLE;
        endcase

        // register writes; the host must issue them only while no item is in flight (the block does not enforce this)
        if (cfg_wr_en) begin
            unique case (mmr_pkg::cfg_idx_t'(cfg_addr))
                mmr_pkg::CFG_SAMPLE_FORMAT:    sample_format_next = cfg_wr_data[0];
                mmr_pkg::CFG_TARGET_MIN:       target_min_next    = $signed(cfg_wr_data);
                mmr_pkg::CFG_TARGET_MAX:       target_max_next    = $signed(cfg_wr_data);
                mmr_pkg::CFG_SELECTED_CHANNEL: sel_ch_next        = cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == mmr_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = {m_rerr_reg, m_sat_reg};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the min-max rescaler
// Drives measure, rescale and clear items into the block under random
// gaps and output stalls, predicts every result from a shadow copy of the
// tracker and registers, and checks results in order field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import mmr_pkg::*;

    localparam int     SHIFT16         = SAMPLE_W - 16;
    localparam longint FS_MAX          = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint FS_MIN          = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam longint PCM16_MIN       = -longint'(PCM16_MAX) - 1;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int     IDLE_LIMIT      = 4000;
    localparam int     HOLD_CYCLES     = 600;
    localparam int     HOLD_AT         = 250;
    localparam int     SETTLE_CYCLES   = 100;
    localparam int     RANDOM_PHASES   = 6;
    localparam int     ITEMS_PER_PHASE = 330;

    localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [6] = '{
        24'h7FFFFF, 24'h800000, 24'h007FFF, 24'hFF8000, 24'h000000, 24'hFFFFFF
    };

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] smp;
    } audio_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                sat;
        logic                rerr;
    } scaled_t;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata  = '0;   // [23:0] sample_in
    logic [4:0]          s_axis_tuser  = '0;   // [1:0] mode, [4:2] channel
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;         // [23:0] sample_out
    logic [1:0]          m_axis_tuser;         // [0] saturated, [1] range_error
    logic                cfg_wr_en     = 1'b0;
    logic [1:0]          cfg_addr      = '0;
    logic [24:0]         cfg_wr_data   = '0;

    min_max_rescale #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // shadow registers and tracker
    logic               fmt_sh   = 1'b0;
    longint             tmin_sh  = TARGET_MIN_RST;
    longint             tmax_sh  = TARGET_MAX_RST;
    logic [CHAN_W-1:0]  sel_sh   = '0;
    longint             run_min  = FS_MAX;
    longint             run_max  = FS_MIN;
    bit                 measured = 1'b0;

    audio_item_t pending_items[$];
    scaled_t     expected_samples[$];

    int items_queued = 0;
    int items_in     = 0;
    int results_seen = 0;
    int rerr_expect  = 0;
    int sat_expect   = 0;
    int mismatches   = 0;

    // sample in tracker units
    function automatic longint to_units(logic [SAMPLE_W-1:0] raw);
        if (fmt_sh == 1'b0)
            return longint'($signed(raw[15:0])) * (longint'(1) <<< SHIFT16);
        return longint'($signed(raw));
    endfunction

    // scale down for 16-bit output (truncating) and clip to the format
    function automatic longint fit_format(longint v, output logic clipped);
        longint lo, hi;
        lo = FS_MIN;
        hi = FS_MAX;
        if (fmt_sh == 1'b0) begin
            v  = v / (longint'(1) <<< SHIFT16);
            lo = PCM16_MIN;
            hi = PCM16_MAX;
        end
        clipped = 1'b0;
        if (v > hi) begin
            v = hi;
            clipped = 1'b1;
        end
        if (v < lo) begin
            v = lo;
            clipped = 1'b1;
        end
        return v;
    endfunction

    // updates the shadow tracker; returns 1 when the item yields a result
    function automatic bit predict_output(audio_item_t it, output scaled_t res);
        bit     hit;
        longint v, s;
        logic   clipped;
        hit     = (it.chan == sel_sh) && (int'(it.chan) < MAX_CHANNELS);
        res     = '0;
        clipped = 1'b0;
        case (it.mode)
            MODE_CLEAR: begin
                run_min  = FS_MAX;
                run_max  = FS_MIN;
                measured = 1'b0;
                return 1'b0;
            end
            MODE_MEASURE: begin
                if (hit) begin
                    s = to_units(it.smp);
                    if (s < run_min) run_min = s;
                    if (s > run_max) run_max = s;
                    measured = 1'b1;
                end
                return 1'b0;
            end
            MODE_RESCALE: begin
                if (!hit) begin
                    res.smp = it.smp;
                    return 1'b1;
                end
                if (!measured || run_max <= run_min) begin
                    v        = fit_format(tmin_sh, clipped);
                    res.rerr = 1'b1;
                end else begin
                    s = to_units(it.smp);
                    v = fit_format((s - run_min) * (tmax_sh - tmin_sh) / (run_max - run_min)
                                   + tmin_sh, clipped);
                end
                res.smp = v[SAMPLE_W-1:0];
                res.sat = clipped;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    // driver: one item per handshake, random gap before each item
    audio_item_t cur_item;
    int          send_gap  = 0;
    bit          send_calm = 1'b0;

    always @(posedge aclk) begin
        scaled_t res;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                items_in++;
                if (predict_output(cur_item, res)) begin
                    expected_samples.push_back(res);
                    rerr_expect += res.rerr;
                    sat_expect  += res.sat;
                end
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 10);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item      = pending_items.pop_front();
                    s_axis_tdata  <= cur_item.smp;
                    s_axis_tuser  <= {cur_item.chan, cur_item.mode};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: in-order check, random stall after each item, one long hold-off
    int recv_stall = 0;
    bit recv_calm  = 1'b0;

    always @(posedge aclk) begin
        scaled_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.smp  = m_axis_tdata;
                got.sat  = m_axis_tuser[0];
                got.rerr = m_axis_tuser[1];
                results_seen++;
                if (expected_samples.size() == 0) begin
                    log_mismatch($sformatf("unexpected result sample %h sat %b rerr %b",
                                           got.smp, got.sat, got.rerr));
                end else begin
                    want = expected_samples.pop_front();
                    if (got.smp !== want.smp || got.sat !== want.sat || got.rerr !== want.rerr)
                        log_mismatch($sformatf(
                            "result %0d: got sample %h sat %b rerr %b, want %h sat %b rerr %b",
                            results_seen, got.smp, got.sat, got.rerr,
                            want.smp, want.sat, want.rerr));
                end
                if (results_seen == HOLD_AT) begin
                    recv_stall = HOLD_CYCLES;
                end else begin
                    if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
                    recv_stall = recv_calm ? 0 : $urandom_range(0, 10);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake or register write
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("min_max_rescale test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(logic [MODE_W-1:0] mode, logic [CHAN_W-1:0] chan,
                             logic [SAMPLE_W-1:0] smp);
        audio_item_t it;
        it.mode = mode;
        it.chan = chan;
        it.smp  = smp;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [TARGET_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            CFG_SAMPLE_FORMAT:    fmt_sh  = val[0];
            CFG_TARGET_MIN:       tmin_sh = longint'($signed(val));
            CFG_TARGET_MAX:       tmax_sh = longint'($signed(val));
            CFG_SELECTED_CHANNEL: sel_sh  = val[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic fmt, longint tmin, longint tmax, logic [CHAN_W-1:0] sel);
        write_reg(CFG_SAMPLE_FORMAT, TARGET_W'(fmt));
        write_reg(CFG_TARGET_MIN, TARGET_W'(tmin));
        write_reg(CFG_TARGET_MAX, TARGET_W'(tmax));
        write_reg(CFG_SELECTED_CHANNEL, TARGET_W'(sel));
    endtask

    // wait for all items and results, then let the pipeline settle
    task automatic drain();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic longint pick_target();
        case ($urandom_range(0, 3))
            0:       return FS_MIN;
            1:       return FS_MAX + 1;
            2:       return longint'($urandom_range(0, 2000)) - 1000;
            default: return longint'($urandom_range(0, 16777216)) + FS_MIN;
        endcase
    endfunction

    // edge values, clusters around a base (narrow ranges), or anything
    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] base);
        case ($urandom_range(0, 7))
            0:       return EDGE_SAMPLES[$urandom_range(0, 5)];
            1, 2, 3: return base + SAMPLE_W'($urandom_range(0, 300));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // clear (most of the time), measure a handful of samples, then rescale some
    task automatic add_sequence();
        logic [SAMPLE_W-1:0] base, smp;
        logic [SAMPLE_W-1:0] seen[$];
        int                  n_meas, n_resc;
        base = SAMPLE_W'($urandom());
        if ($urandom_range(0, 3) != 0)
            push_item(MODE_CLEAR, CHAN_W'($urandom()), SAMPLE_W'($urandom()));
        n_meas = $urandom_range(1, 10);
        repeat (n_meas) begin
            smp = pick_sample(base);
            if ($urandom_range(0, 4) == 0) begin
                push_item(MODE_MEASURE, CHAN_W'($urandom()), smp);
            end else begin
                push_item(MODE_MEASURE, sel_sh, smp);
                seen.push_back(smp);
            end
        end
        n_resc = $urandom_range(1, 12);
        repeat (n_resc) begin
            if (seen.size() != 0 && $urandom_range(0, 1) == 0)
                smp = seen[$urandom_range(0, seen.size() - 1)];
            else
                smp = pick_sample(base);
            push_item(MODE_RESCALE,
                      ($urandom_range(0, 5) == 0) ? CHAN_W'($urandom()) : sel_sh, smp);
        end
    endtask

    // stimulus and end of run
    initial begin
        int goal;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: 16-bit, full-scale targets, channel 0
        push_item(MODE_RESCALE, 3'd0, 24'h001234);  // nothing measured yet
        push_item(MODE_MEASURE, 3'd0, 24'hAB7FFF);  // upper bits ignored in 16-bit
        push_item(MODE_RESCALE, 3'd0, 24'h000000);  // max equals min
        push_item(MODE_MEASURE, 3'd0, 24'h5A8000);
        push_item(MODE_MEASURE, 3'd5, 24'h000100);  // other channel, no effect
        push_item(MODE_UNUSED,  3'd0, 24'h7FFFFF);  // ignored mode
        push_item(MODE_RESCALE, 3'd0, 24'h008000);  // at min
        push_item(MODE_RESCALE, 3'd0, 24'h007FFF);  // at max
        push_item(MODE_RESCALE, 3'd0, 24'h000000);
        push_item(MODE_RESCALE, 3'd0, 24'hFFFFFF);
        push_item(MODE_RESCALE, 3'd7, 24'hFFFFFF);  // passthrough
        push_item(MODE_RESCALE, 3'd1, 24'h800000);
        push_item(MODE_RESCALE, 3'd2, 24'h7FFFFF);
        push_item(MODE_RESCALE, 3'd4, 24'h000000);
        push_item(MODE_CLEAR,   3'd3, 24'h000000);
        push_item(MODE_RESCALE, 3'd0, 24'h000000);  // cleared tracker
        push_item(MODE_MEASURE, 3'd0, 24'h000010);  // narrow range
        push_item(MODE_MEASURE, 3'd0, 24'h000011);
        push_item(MODE_RESCALE, 3'd0, 24'h007FFF);  // far above max, clips high
        push_item(MODE_RESCALE, 3'd0, 24'h008000);  // far below min, clips low
        drain();

        // 24-bit, reversed targets beyond full scale, channel 7
        set_config(1'b1, FS_MAX + 1, FS_MIN, 3'd7);
        push_item(MODE_RESCALE, 3'd7, 24'h000000);  // range error with clipped target
        push_item(MODE_MEASURE, 3'd7, 24'h800000);
        push_item(MODE_MEASURE, 3'd7, 24'h7FFFFF);
        push_item(MODE_RESCALE, 3'd7, 24'h800000);
        push_item(MODE_RESCALE, 3'd7, 24'h7FFFFF);
        push_item(MODE_RESCALE, 3'd7, 24'h000000);
        push_item(MODE_RESCALE, 3'd6, 24'h123456);
        drain();

        // random phases, extremes of the settings first
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       set_config(1'b1, FS_MIN, FS_MAX, CHAN_W'($urandom()));
                1:       set_config(1'b0, FS_MAX + 1, FS_MIN, CHAN_W'($urandom()));
                2:       set_config(1'b1, FS_MIN, FS_MAX + 1, CHAN_W'($urandom()));
                default: set_config(1'($urandom()), pick_target(), pick_target(),
                                    CHAN_W'($urandom()));
            endcase
            goal = items_queued + ITEMS_PER_PHASE;
            while (items_queued < goal) begin
                if ($urandom_range(0, 9) == 0)
                    push_item(MODE_W'($urandom_range(0, 3)), CHAN_W'($urandom()),
                              SAMPLE_W'($urandom()));
                else
                    add_sequence();
            end
            drain();
        end

        $display("run covered %0d items over %0d register settings and %0d checked results",
                 items_in, RANDOM_PHASES + 2, results_seen);
        $display("of those results %0d flagged a range error and %0d were clipped",
                 rerr_expect, sat_expect);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("min_max_rescale test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_samples.size());
            $display("min_max_rescale test failed");
        end
        $finish;
    end

endmodule
